[rtl/stbs_pkg.sv]
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 11;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 3'd0,
        FUNC_LOWER = 3'd1,
        FUNC_UPPER = 3'd2,
        FUNC_FLOOR = 3'd3,
        FUNC_CEIL  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        KIND_GE,
        KIND_GT,
        KIND_LE
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

endpackage

[rtl/sorted_table_bound_search.sv]
// Write request: accepted while idle; the state stays ST_IDLE, so the input stays ready.
// Query request: P probes, one per cycle through the registered table read port,
// P at most floor(log2(count))+1 (0 for an empty table, 11 for 1024 entries).
// The result is loaded from ST_DONE; the input is ready again back in ST_IDLE.
// A full output register stalls ST_DONE until m_axis_tready.
// Reset clears entry_count and control state; table contents stay undefined.
module sorted_table_bound_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [9:0] entry_index, [41:10] value, [47:42] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] func
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [10:0] position, [42:11] element, [47:43] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic                 m_axis_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

    logic [COUNT_W-1:0] r_entry_count;
    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hip1, n_hip1;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_mid, n_mid;
    logic [AW-1:0]      r_ans, n_ans;
    logic [VALUE_W-1:0] r_key, n_key;
    logic [VALUE_W-1:0] r_elem, n_elem;
    logic               r_found, n_found;

    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [VALUE_W-1:0] r_out_elem;
    logic               r_out_found;

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    logic               w_in_acc;
    t_func              w_func;
    logic [INDEX_W-1:0] w_idx;
    logic [VALUE_W-1:0] w_val;
    logic [31:0]        w_idx32;
    logic [CW-1:0]      w_count_sat;
    logic               w_we;
    logic [AW-1:0]      w_rd_addr;
    logic               w_start;
    logic               w_hit;
    logic               w_load;
    logic [POS_W-1:0]   w_pos;

    function automatic logic [AW-1:0] f_mid(input logic [CW-1:0] lo, input logic [CW-1:0] hip1);
        logic [CW:0] s;
        s = ({1'b0, lo} + {1'b0, hip1}) - (CW+1)'(1);
        return s[AW:1];
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(r_entry_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_COUNT) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_func        = t_func'(s_axis_tuser);
    assign w_idx         = s_axis_tdata[INDEX_W-1:0];
    assign w_val         = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign w_idx32       = 32'(w_idx);
    assign w_count_sat   = (32'(r_entry_count) > DEPTH32) ? CW'(TABLE_DEPTH)
                                                          : CW'(r_entry_count);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_lo    = r_lo;
        n_hip1  = r_hip1;
        n_count = r_count;
        n_ans   = r_ans;
        n_key   = r_key;
        n_elem  = r_elem;
        n_found = r_found;
        w_we    = 1'b0;
        w_start = 1'b0;
        w_hit   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_func)
                        FUNC_WRITE: w_we = (w_idx32 < DEPTH32);
                        FUNC_LOWER, FUNC_CEIL: begin
                            w_start = 1'b1;
                            n_kind  = KIND_GE;
                        end
                        FUNC_UPPER: begin
                            w_start = 1'b1;
                            n_kind  = KIND_GT;
                        end
                        FUNC_FLOOR: begin
                            w_start = 1'b1;
                            n_kind  = KIND_LE;
                        end
                        default: ;
                    endcase
                    if (w_start) begin
                        n_lo    = '0;
                        n_hip1  = w_count_sat;
                        n_count = w_count_sat;
                        n_key   = w_val;
                        n_ans   = '0;
                        n_elem  = '0;
                        n_found = 1'b0;
                        n_state = (w_count_sat != '0) ? ST_PROBE : ST_DONE;
                    end
                end
            end
            ST_PROBE: begin
                unique case (r_kind)
                    KIND_GE: w_hit = $signed(r_rd_data) >= $signed(r_key);
                    KIND_GT: w_hit = $signed(r_rd_data) >  $signed(r_key);
                    default: w_hit = $signed(r_rd_data) <= $signed(r_key);
                endcase
                if (w_hit) begin
                    n_ans   = r_mid;
                    n_elem  = r_rd_data;
                    n_found = 1'b1;
                end
                if (w_hit == (r_kind == KIND_LE)) begin
                    n_lo = CW'({1'b0, r_mid}) + CW'(1);
                end else begin
                    n_hip1 = CW'({1'b0, r_mid});
                end
                n_state = (n_lo < n_hip1) ? ST_PROBE : ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_mid     = f_mid(n_lo, n_hip1);
        w_rd_addr = n_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_lo    <= n_lo;
        r_hip1  <= n_hip1;
        r_count <= n_count;
        r_mid   <= n_mid;
        r_ans   <= n_ans;
        r_key   <= n_key;
        r_elem  <= n_elem;
        r_found <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_idx32[AW-1:0]] <= w_val;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign w_pos = r_found ? POS_W'(32'(r_ans)) : POS_W'(32'(r_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pos   <= w_pos;
            r_out_elem  <= r_elem;
            r_out_found <= r_found;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W-POS_W-VALUE_W)'(0), r_out_elem, r_out_pos};
    assign m_axis_tuser  = r_out_found;

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PROBE |-> r_lo < r_hip1)
        else $error("probe issued with empty search range");

    a_bound_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_hip1 <= r_count)
        else $error("search bound beyond entry count");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[42:11] == '0)
        else $error("element nonzero on miss");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_state == ST_DONE && !s_axis_tready)
        else $error("result load outside done state");

endmodule
